### rtl/ultrasonic_level_averager_unit_assert.svh
// ----------------------------------------------------------------------------
// Ultrasonic level averager assertion macros
// Shared property forms for the averager's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_LEVEL_AVERAGER_UNIT_ASSERT_SVH
`define ULTRASONIC_LEVEL_AVERAGER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ULAVG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ulavg: same-cycle check failed");

// next-cycle implication, checked out of reset
`define ULAVG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ulavg: next-cycle check failed");

`endif

### rtl/ulavg_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic level averager package
// Widths, constants, register indexes and types shared by the averager.
// ----------------------------------------------------------------------------
`default_nettype none

package ulavg_pkg;

	localparam int ULAVG_SAMPLES = 8;

	localparam int ECHO_W  = 16;
	localparam int RANGE_W = 11;
	localparam int CM_W    = 11;
	localparam int SUM_W   = 17;
	localparam int SMP_W   = 7;
	localparam int LEVEL_W = 7;
	localparam int CFG_IW  = 2;
	localparam int CM_NW   = 9;

	localparam logic [CM_NW-1:0] CM_NUM  = 9'd343;
	localparam logic [SUM_W-1:0] CM_DEN  = 17'd20000;
	localparam logic [SMP_W-1:0] PCT_MUL = 7'd100;

	localparam logic [RANGE_W-1:0] RANGE_HIGH_RST = 11'd200;
	localparam logic [RANGE_W-1:0] RANGE_LOW_RST  = 11'd20;

	localparam int DIV_NW = 25;
	localparam int DIV_DW = SUM_W;
	localparam int DIV_CW = $clog2(DIV_NW);

	localparam logic [CFG_IW-1:0] REG_RANGE_HIGH = 2'd0;
	localparam logic [CFG_IW-1:0] REG_RANGE_LOW  = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TOTALS,
		ST_CHECK,
		ST_START,
		ST_LEVEL,
		ST_EMIT
	} ulavg_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sdiv_stat_t;

endpackage

`default_nettype wire

### rtl/ulavg_sdiv.sv
// ----------------------------------------------------------------------------
// Ultrasonic level averager serial divider
// Restoring divider, one quotient bit per cycle for a DIV_NW-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ulavg_sdiv import ulavg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output sdiv_stat_t        stat,
	output logic [DIV_NW-1:0] quotient
);

	logic [DIV_NW-1:0] shift_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dsr_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW+1:0] diff;
	logic              ge;

	assign trial = {rem_q, shift_q[DIV_NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};
	assign ge    = !diff[DIV_DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			dsr_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[DIV_NW-2:0], ge};
			rem_q   <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = shift_q;

endmodule

`default_nettype wire

### rtl/ultrasonic_level_averager_unit.sv
// ----------------------------------------------------------------------------
// Ultrasonic level averager
// Converts echo widths to centimetres, averages SAMPLES of them and reports
// the tank level in percent of the configured span, or a sensor error.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries echo_time_us; one transfer per echo.
// Output channel out_valid/out_ready carries level_percent and sensor_error;
// one transfer per group of SAMPLES echoes, on the last echo of the group.
// cfg_we/cfg_index/cfg_data write range_high_cm (index 0) and range_low_cm
// (index 1); other indexes are ignored. Write only while the block is idle.
// Each echo holds in_ready low after its transfer while the shared
// bit-serial divider turns the echo into centimetres.
// After the last echo of a group the block steps through three setup
// states (ST_TOTALS, ST_CHECK, ST_START), a second pass of the same divider
// in ST_LEVEL, and ST_EMIT, which waits for the output register to free,
// loads it and raises out_valid. A sensor error skips ST_START and the
// divider and goes from ST_CHECK straight to ST_EMIT.
// One echo is in work at a time. The result sits in an output register, so
// in_ready returns while an earlier result still waits; if the receiver
// stalls with a result waiting, the next result is held inside until the
// output register frees.
// Reset clears the sample count and sum, drops out_valid and restores the
// ranges to 200 cm and 20 cm.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ultrasonic_level_averager_unit_assert.svh"

module ultrasonic_level_averager_unit import ulavg_pkg::*; #(
	parameter int SAMPLES = ULAVG_SAMPLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ECHO_W-1:0]  echo_time_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [LEVEL_W-1:0] level_percent,
	output logic               sensor_error,
	input  logic               cfg_we,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [RANGE_W-1:0] cfg_data
);

	localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);
	localparam logic [SMP_W-1:0] SAMPLES_V = SMP_W'(SAMPLES);

	ulavg_state_t state_q, state_d;

	logic [RANGE_W-1:0] range_high_q;
	logic [RANGE_W-1:0] range_low_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   hi_tot_q;
	logic [SUM_W-1:0]   lo_tot_q;
	logic [SUM_W-1:0]   diff_q;
	logic [SUM_W-1:0]   den_q;
	logic [LEVEL_W-1:0] res_level_q;
	logic               res_err_q;
	logic [LEVEL_W-1:0] level_q;
	logic               err_q;
	logic               out_valid_q;

	logic                       div_start;
	logic [DIV_NW-1:0]          div_dividend;
	logic [DIV_DW-1:0]          div_divisor;
	logic [DIV_NW-1:0]          div_quot;
	sdiv_stat_t                 div_st;
	logic [DIV_NW-1:0]          echo_prod;
	logic [RANGE_W+SMP_W-1:0]   hi_prod;
	logic [RANGE_W+SMP_W-1:0]   lo_prod;
	logic [SUM_W+SMP_W-1:0]     num_prod;
	logic [SUM_W-1:0]           new_sum;
	logic                       range_err;
	logic                       out_free;
	logic                       in_xfer;

	assign echo_prod = DIV_NW'({{CM_NW{1'b0}}, echo_time_us} * {{ECHO_W{1'b0}}, CM_NUM});
	assign hi_prod   = {{SMP_W{1'b0}}, range_high_q} * {{RANGE_W{1'b0}}, SAMPLES_V};
	assign lo_prod   = {{SMP_W{1'b0}}, range_low_q} * {{RANGE_W{1'b0}}, SAMPLES_V};
	assign num_prod  = {{SMP_W{1'b0}}, diff_q} * {{SUM_W{1'b0}}, PCT_MUL};
	assign new_sum   = sum_q + SUM_W'(div_quot[CM_W-1:0]);
	assign range_err = (range_high_q == range_low_q) || (sum_q > hi_tot_q)
		|| (sum_q < lo_tot_q);
	assign out_free  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;

	ulavg_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_st),
		.quotient (div_quot)
	);

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = echo_prod;
		div_divisor  = CM_DEN;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid;
				if (in_valid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (div_st.done) begin
					state_d = (count_q == CNT_LAST) ? ST_TOTALS : ST_IDLE;
				end
			end
			ST_TOTALS: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = range_err ? ST_EMIT : ST_START;
			end
			ST_START: begin
				div_start    = 1'b1;
				div_dividend = DIV_NW'(num_prod);
				div_divisor  = den_q;
				state_d      = ST_LEVEL;
			end
			ST_LEVEL: begin
				if (div_st.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			range_high_q <= RANGE_HIGH_RST;
			range_low_q  <= RANGE_LOW_RST;
			count_q      <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_RANGE_HIGH) begin
				range_high_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_RANGE_LOW) begin
				range_low_q <= cfg_data;
			end
			if (state_q == ST_CONV && div_st.done) begin
				sum_q   <= new_sum;
				count_q <= (count_q == CNT_LAST) ? '0 : count_q + 1'b1;
			end
			if (state_q == ST_CHECK) begin
				sum_q <= '0;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TOTALS) begin
			hi_tot_q <= hi_prod[SUM_W-1:0];
			lo_tot_q <= lo_prod[SUM_W-1:0];
		end
		if (state_q == ST_CHECK) begin
			diff_q      <= hi_tot_q - sum_q;
			den_q       <= hi_tot_q - lo_tot_q;
			res_level_q <= '0;
			res_err_q   <= range_err;
		end
		if (state_q == ST_LEVEL && div_st.done) begin
			res_level_q <= div_quot[LEVEL_W-1:0];
			res_err_q   <= 1'b0;
		end
		if (state_q == ST_EMIT && out_free) begin
			level_q <= res_level_q;
			err_q   <= res_err_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign level_percent = level_q;
	assign sensor_error  = err_q;

	`ULAVG_ASSERT_NOW(a_idle_div_quiet, in_ready, !div_st.busy)
	`ULAVG_ASSERT_NOW(a_done_in_wait, div_st.done, state_q == ST_CONV || state_q == ST_LEVEL)
	`ULAVG_ASSERT_NEXT(a_one_in_work, in_xfer, !in_ready)
	`ULAVG_ASSERT_NOW(a_err_zero_level, out_valid && sensor_error, level_percent == '0)

endmodule

`default_nettype wire
